>>> hw/rtl/qfx_pkg.sv
// Package for the Q-format fixed-point ALU: request codes and shared types.
// No dependencies.
`default_nettype none
package qfx_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_I2F = 3'd4,
    OP_F2I = 3'd5,
    OP_NONE6 = 3'd6,
    OP_NONE7 = 3'd7
  } op_t;
  localparam int FIELD_W = 32;
endpackage
`default_nettype wire

>>> hw/rtl/qfx_if.sv
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on nothing.
`default_nettype none
interface qfx_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface qfx_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        divide_by_zero;
  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink (input valid, result_value, divide_by_zero, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/qfx_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; stall via advance enable.
`default_nettype none
module qfx_divider #(
  parameter int W = 32,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [W-1:0]  num,
  input  wire logic [W-1:0]  den,
  input  wire logic [TW-1:0] tag_in,
  output logic [W-1:0]       quo,
  output logic [TW-1:0]      tag_out
);
  logic [W-1:0]  n_s [W+1];
  logic [W-1:0]  d_s [W+1];
  logic [W:0]    r_s [W+1];
  logic [TW-1:0] t_s [W+1];

  assign n_s[0] = num;
  assign d_s[0] = den;
  assign r_s[0] = '0;
  assign t_s[0] = tag_in;

  for (genvar i = 0; i < W; i++) begin : g_st
    logic [W:0] sh;
    logic [W:0] df;
    logic [W-1:0] n_q;
    logic [W-1:0] d_q;
    logic [W:0] r_q;
    logic [TW-1:0] t_q;
    assign sh = {r_s[i][W-1:0], n_s[i][W-1]};
    assign df = sh - {1'b0, d_s[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_q <= d_s[i];
        t_q <= t_s[i];
        if (!df[W]) begin
          r_q <= df;
          n_q <= {n_s[i][W-2:0], 1'b1};
        end else begin
          r_q <= sh;
          n_q <= {n_s[i][W-2:0], 1'b0};
        end
      end
    end
    assign n_s[i+1] = n_q;
    assign d_s[i+1] = d_q;
    assign r_s[i+1] = r_q;
    assign t_s[i+1] = t_q;
  end

  assign quo = n_s[W];
  assign tag_out = t_s[W];
endmodule
`default_nettype wire

>>> hw/rtl/qfx_datapath.sv
// ALU datapath: decode/prep stage, multiply and divide pipes, output stage.
// Depends on qfx_pkg and qfx_divider.
`default_nettype none
module qfx_datapath
  import qfx_pkg::*;
#(
  parameter int FRACTION_BITS = 14,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic [2:0]         req_type,
  input  wire logic [FIELD_W-1:0] operand_a,
  input  wire logic [FIELD_W-1:0] operand_b,
  output logic                    out_valid,
  output logic [FIELD_W-1:0]      result_value,
  output logic                    divide_by_zero
);
  localparam int DW = DATA_WIDTH;
  localparam int HW = (DW + 1) / 2;
  localparam int TW = 3 + DW + 1;
  localparam logic [DW-1:0] RND = DW'(1) << (FRACTION_BITS - 1);

  function automatic logic [DW-1:0] sx(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[DW-1:0];
  endfunction

  logic [DW-1:0] a_w, b_w;
  assign a_w = sx(operand_a);
  assign b_w = sx(operand_b);

  // stage 1: prep
  logic          s1_v;
  op_t           s1_op;
  logic [DW-1:0] s1_simple, s1_a, s1_b, s1_num, s1_den;
  logic          s1_neg, s1_dz;
  logic [DW-1:0] t_w, half_w, t_adj, bmag, tmag, a_mag, m_w;
  always_comb begin
    t_w = a_w << FRACTION_BITS;
    bmag = b_w[DW-1] ? -b_w : b_w;
    half_w = b_w[DW-1] ? -(bmag >> 1) : (bmag >> 1);
    t_adj = (t_w[DW-1] == b_w[DW-1]) ? t_w + half_w : t_w - half_w;
    tmag = t_adj[DW-1] ? -t_adj : t_adj;
    a_mag = a_w[DW-1] ? -a_w : a_w;
    m_w = a_mag >> FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= op_t'(req_type);
      s1_a <= a_w;
      s1_b <= b_w;
      s1_num <= tmag;
      s1_den <= bmag;
      s1_neg <= t_adj[DW-1] ^ b_w[DW-1];
      s1_dz <= (op_t'(req_type) == OP_DIV) && (b_w == '0);
      unique case (op_t'(req_type))
        OP_ADD: s1_simple <= a_w + b_w;
        OP_SUB: s1_simple <= a_w - b_w;
        OP_I2F: s1_simple <= t_w;
        OP_F2I: s1_simple <= a_w[DW-1] ? -m_w : m_w;
        default: s1_simple <= '0;
      endcase
    end
  end

  // stage 2-3: multiply as partial products, low DW bits only
  logic [DW-1:0] pp_ll, pp_x;
  logic [DW-1:0] mul_s2;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_ll <= DW'({{DW{1'b0}}, s1_a[HW-1:0]} * {{DW{1'b0}}, s1_b[HW-1:0]});
      pp_x <= (DW'(s1_a[DW-1:HW]) * DW'(s1_b[HW-1:0]) +
               DW'(s1_a[HW-1:0]) * DW'(s1_b[DW-1:HW])) << HW;
    end
  end
  logic [DW-1:0] prod;
  assign prod = pp_ll + pp_x + RND;
  always_ff @(posedge clk) begin
    if (adv) mul_s2 <= DW'($signed(prod) >>> FRACTION_BITS);
  end

  // divider, tag carries the rest of the word
  logic [TW-1:0] tag_in, tag_out;
  logic [DW-1:0] quo;
  assign tag_in = {s1_op, s1_simple, s1_neg};
  qfx_divider #(.W(DW), .TW(TW)) u_div (
    .clk(clk), .adv(adv), .num(s1_num), .den(s1_den | DW'(s1_dz)),
    .tag_in(tag_in), .quo(quo), .tag_out(tag_out)
  );

  // multiply and dz delayed to match divider latency
  localparam int DL = DW - 2;
  logic [DW-1:0] mdl [DL+1];
  logic          zdl [DW+1];
  logic          vdl [DW+1];
  assign mdl[0] = mul_s2;
  assign zdl[0] = s1_dz;
  assign vdl[0] = s1_v;
  for (genvar k = 0; k < DL; k++) begin : g_md
    always_ff @(posedge clk) if (adv) mdl[k+1] <= mdl[k];
  end
  for (genvar k = 0; k < DW; k++) begin : g_zd
    always_ff @(posedge clk) if (adv) zdl[k+1] <= zdl[k];
    always_ff @(posedge clk) begin
      if (rst) vdl[k+1] <= 1'b0;
      else if (adv) vdl[k+1] <= vdl[k];
    end
  end

  op_t           f_op;
  logic [DW-1:0] f_simple, f_res;
  logic          f_neg;
  assign f_op = op_t'(tag_out[TW-1 -: 3]);
  assign f_simple = tag_out[DW:1];
  assign f_neg = tag_out[0];
  always_comb begin
    unique case (f_op)
      OP_MUL: f_res = mdl[DL];
      OP_DIV: f_res = zdl[DW] ? '0 : (f_neg ? -quo : quo);
      default: f_res = f_simple;
    endcase
  end

  logic [63:0] f_ext;
  assign f_ext = {{(64-DW){f_res[DW-1]}}, f_res};
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vdl[DW];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= f_ext[31:0];
      divide_by_zero <= zdl[DW];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/q14_fixed_point_alu_top.sv
// Q-format fixed-point ALU, top level.
// Depends on qfx_pkg, qfx_if, qfx_datapath.
//
// Usage: requests arrive on channel req (req_type, operand_a, operand_b),
// results leave on channel rsp (result_value, divide_by_zero), one result
// word per request word, in order.
// The pipeline depth is set by the divider pipe, one quotient bit per stage;
// all operations go through the same depth so order holds.
// Throughput: one word per cycle while the receiver does not stall.
// The whole pipe advances when rsp is empty or taken; when the receiver
// stalls with a word held, the pipe freezes and req.ready drops, so nothing
// is lost or repeated.
// Reset clears all valid bits; the block is empty after reset.
// Divide by zero yields zero with the flag set; codes 6 and 7 yield zero.
//
`default_nettype none
module q14_fixed_point_alu_top
  import qfx_pkg::*;
#(
  parameter int FRACTION_BITS = 14,
  parameter int DATA_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  qfx_req_if.sink  req,
  qfx_rsp_if.source rsp
);
  logic adv;
  assign adv = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  qfx_datapath #(.FRACTION_BITS(FRACTION_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(req.valid),
    .req_type(req.req_type), .operand_a(req.operand_a), .operand_b(req.operand_b),
    .out_valid(rsp.valid), .result_value(rsp.result_value),
    .divide_by_zero(rsp.divide_by_zero)
  );
endmodule
`default_nettype wire

>>> hw/rtl/qfx_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on q14_fixed_point_alu_top and its qfx_if ports.
`default_nettype none
module qfx_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [31:0] rsp_result,
  input wire logic rsp_dz
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_dz))
    else $error("rsp word changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while pipe stalled");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dz |-> rsp_result == 32'd0)
    else $error("divide by zero with nonzero result");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("valid after reset");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> !$isunknown(req_ready))
    else $error("req ready unknown while offered");
endmodule

bind q14_fixed_point_alu_top qfx_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.result_value),
  .rsp_dz(rsp.divide_by_zero)
);
`default_nettype wire

>>> bench/tb.sv
// Testbench for q14_fixed_point_alu_top: drives request words, predicts each
// result in Q14 arithmetic and checks the response stream in order.
// Depends on qfx_pkg, qfx_if and the RTL top level.
`timescale 1ns / 100ps
module tb;
  import qfx_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic               dz;
  } alu_out_t;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  qfx_req_if req ();
  qfx_rsp_if rsp ();

  q14_fixed_point_alu_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  alu_out_t expected_q[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       rx_hold = 0;
  bit       rx_no_idle = 0;
  bit       tx_no_idle = 0;

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] tdiv(logic [31:0] n, logic [31:0] d);
    logic [31:0] q;
    q = mag(n) / mag(d);
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic alu_out_t q14_compute(op_t op, logic [31:0] a, logic [31:0] b);
    alu_out_t    r;
    logic [31:0] t;
    logic [31:0] half;
    r.value = '0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        t = a * b;
        t = t + 32'd8192;
        r.value = $signed(t) >>> 14;
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          t = a << 14;
          half = tdiv(b, 32'd2);
          t = (t[31] == b[31]) ? t + half : t - half;
          r.value = tdiv(t, b);
        end
      end
      OP_I2F: r.value = a << 14;
      OP_F2I: begin
        t = mag(a) >> 14;
        r.value = a[31] ? -t : t;
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  task automatic send_word(op_t op, logic [31:0] a, logic [31:0] b);
    while (!tx_no_idle && $urandom_range(99) < 21) @(negedge clk);
    req.valid = 1'b1;
    req.req_type = op;
    req.operand_a = a;
    req.operand_b = b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back(q14_compute(op, a, b));
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst || rx_hold) rsp.ready <= 1'b0;
    else rsp.ready <= rx_no_idle || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word value=%0d dz=%0b", $time, rsp.result_value,
                 rsp.divide_by_zero);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.result_value !== e.value) begin
          $display("%0t value mismatch exp=%h act=%h", $time, e.value, rsp.result_value);
          errors++;
        end
        if (rsp.divide_by_zero !== e.dz) begin
          $display("%0t flag mismatch exp=%0b act=%0b", $time, e.dz, rsp.divide_by_zero);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3) - 32'd1;
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      4: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h4000};
    for (int i = 0; i < 8; i++) send_word(op_t'(i), 32'h0001_2345, 32'hfffe_1234);
    send_word(OP_DIV, 32'h4000, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_c000);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_DIV, 32'hffff_a000, 32'h3);
    send_word(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_F2I, 32'hffff_bfff, 32'h0);
    foreach (ext[i]) send_word(op_t'(i), ext[i], ext[4 - i]);
    send_word(OP_F2I, 32'h8000_0000, 32'h0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_word(op_t'($urandom_range(99) < 95 ? $urandom_range(5) : $urandom_range(7, 6)),
                rand_operand(), $urandom_range(9) == 0 ? 32'h0 : rand_operand());
  endtask

  task automatic test_no_idle();
    rx_no_idle = 1;
    tx_no_idle = 1;
    test_random(100);
    rx_no_idle = 0;
    tx_no_idle = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1;
        repeat (120) @(negedge clk);
        rx_hold = 0;
      end
      test_random(60);
    join
    drain();
  endtask

  initial begin
    req.valid = 0;
    req.req_type = OP_ADD;
    req.operand_a = 0;
    req.operand_b = 0;
    rsp.ready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    drain();
    test_random(250);
    test_no_idle();
    test_backpressure();
    test_random(180);
    drain();
    repeat (40) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> q14_fixed_point_alu_top.f
hw/rtl/qfx_pkg.sv
hw/rtl/qfx_if.sv
hw/rtl/qfx_divider.sv
hw/rtl/qfx_datapath.sv
hw/rtl/q14_fixed_point_alu_top.sv
hw/rtl/qfx_checker.sv
bench/tb.sv
